>>> hdl/rtq_pkg.sv
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared constants and types for the resistive touch qualifier.
// ----------------------------------------------------------------------------
package rtq_pkg;

  localparam int ADC_BITS  = 12;
  localparam int COEF_W    = 32;   // calibration register width
  localparam int CRD_W     = 10;   // scaled coordinate width (< 1024)
  localparam int POS_W     = 16;
  localparam int ACC_W     = 44;   // MAC accumulator, covers 2^31 * 1790 + 2^31
  localparam int NUM_W     = 44;   // divider dividend width
  localparam int DEN_W     = 32;   // divider divisor width
  localparam int IDX_W     = 3;
  localparam int PRESS_W   = 12;   // min_pressure register width

  localparam int RES_X     = 610;
  localparam int RES_Y     = 380;
  localparam int JUMP_MAX  = 250;
  localparam int RES_MAX   = 1300000;
  localparam int SCALE_H   = 768;
  localparam int MILLI     = 1000;
  localparam int MIN_PRESS_RESET = 100;

  // register indexes
  localparam logic [IDX_W-1:0] REG_XX_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_XY_GAIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_OFFSET  = 3'd2;
  localparam logic [IDX_W-1:0] REG_YX_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_YY_GAIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_OFFSET  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIVISOR   = 3'd6;
  localparam logic [IDX_W-1:0] REG_MIN_PRESS = 3'd7;

  typedef struct packed {
    logic en;     // update accumulator this cycle
    logic accum;  // 1: add to accumulator, 0: start from addend
  } mac_ctl_t;

endpackage

>>> hdl/rtq_in_if.sv
// ----------------------------------------------------------------------------
// rtq_in_if
// Sample channel: raw X, Y, Z1 conversions with valid/ready.
// ----------------------------------------------------------------------------
interface rtq_in_if #(
  parameter int ADC_BITS = rtq_pkg::ADC_BITS
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] x_sample;
  logic [ADC_BITS-1:0] y_sample;
  logic [ADC_BITS-1:0] z1_sample;

  modport source (output valid, x_sample, y_sample, z1_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, z1_sample, output ready);
endinterface

>>> hdl/rtq_out_if.sv
// ----------------------------------------------------------------------------
// rtq_out_if
// Report channel: calibrated point and press/release flags with valid/ready.
// ----------------------------------------------------------------------------
interface rtq_out_if;
  logic                      valid;
  logic                      ready;
  logic [rtq_pkg::POS_W-1:0] pos_x;
  logic [rtq_pkg::POS_W-1:0] pos_y;
  logic                      pressed;
  logic                      last;

  modport source (output valid, pos_x, pos_y, pressed, last, input ready);
  modport sink   (input valid, pos_x, pos_y, pressed, last, output ready);
endinterface

>>> hdl/rtq_div.sv
// ----------------------------------------------------------------------------
// rtq_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rtq_pkg::NUM_W-1:0]   num,
  input  logic [rtq_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [rtq_pkg::NUM_W-1:0]   quo
);
  localparam int NW = rtq_pkg::NUM_W;
  localparam int DW = rtq_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num_r;
  logic [DW:0]   rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem[DW-1:0], num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign quo    = num_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      rem   <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_r <= {num_r[NW-2:0], ge};
    end
  end
endmodule

>>> hdl/rtq_mac.sv
// ----------------------------------------------------------------------------
// rtq_mac
// Shared signed multiply-accumulate: acc = (acc or addend) + a * b.
// ----------------------------------------------------------------------------
module rtq_mac (
  input  logic                               clk,
  input  rtq_pkg::mac_ctl_t                  ctl,
  input  logic signed [rtq_pkg::COEF_W-1:0]  a,
  input  logic        [rtq_pkg::CRD_W-1:0]   b,
  input  logic signed [rtq_pkg::ACC_W-1:0]   addend,
  output logic signed [rtq_pkg::ACC_W-1:0]   acc
);
  localparam int PW = rtq_pkg::COEF_W + rtq_pkg::CRD_W + 1;

  logic signed [PW-1:0]             prod;
  logic signed [rtq_pkg::ACC_W-1:0] base;

  assign prod = a * $signed({1'b0, b});
  assign base = ctl.accum ? acc : addend;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + rtq_pkg::ACC_W'(prod);
    end
  end
endmodule

>>> hdl/resistive_touch_qualifier.sv
// ----------------------------------------------------------------------------
// resistive_touch_qualifier
// Touch sample qualifier with pressure filter and affine calibration.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one X, Y, Z1 conversion set per transfer (valid/ready).
//   reports : zero, one or two results per sample; last marks the final one.
//   cfg_*   : write-only register port, written while the block is idle.
// Sequencing:
//   A sample with Z1 = 0 skips the resistance division.
//   Other samples run the shared divider once for the touch resistance; a
//   press report with calibration runs it twice more. Without calibration
//   (divisor 0) a press report goes from ST_MAP straight to report delivery.
//   samples.ready is high only while the sequencer is idle; the shared
//   divider and multiply-accumulate unit set the rate.
// Reset: registers return to their defaults, nothing is held, no report.
// A stalled receiver holds the report register; the sequencer waits until
// it drains before loading the next report.
// ----------------------------------------------------------------------------
module resistive_touch_qualifier #(
  parameter int ADC_BITS = rtq_pkg::ADC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rtq_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rtq_pkg::COEF_W-1:0]        cfg_data,
  rtq_in_if.sink                            samples,
  rtq_out_if.source                         reports
);
  localparam int AW = rtq_pkg::ACC_W;
  localparam int NW = rtq_pkg::NUM_W;
  localparam int DW = rtq_pkg::DEN_W;
  localparam int KW = rtq_pkg::COEF_W;
  localparam int CW = rtq_pkg::CRD_W;
  localparam int PW = rtq_pkg::POS_W;
  localparam int EW = ADC_BITS + 10;
  localparam logic [ADC_BITS-1:0] ADC_MASK = '1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDIV   = 4'd1;
  localparam logic [3:0] ST_CLASS  = 4'd2;
  localparam logic [3:0] ST_MAP    = 4'd3;
  localparam logic [3:0] ST_MAPX2  = 4'd4;
  localparam logic [3:0] ST_XSTART = 4'd5;
  localparam logic [3:0] ST_XDIV   = 4'd6;
  localparam logic [3:0] ST_MAPY2  = 4'd7;
  localparam logic [3:0] ST_YSTART = 4'd8;
  localparam logic [3:0] ST_YDIV   = 4'd9;
  localparam logic [3:0] ST_EMIT_P = 4'd10;
  localparam logic [3:0] ST_EMIT_R = 4'd11;

  // configuration
  logic signed [KW-1:0]             cal [7];
  logic [rtq_pkg::PRESS_W-1:0]      min_press;

  // state
  logic [3:0]          state;
  logic [ADC_BITS-1:0] cur_x, cur_y, cur_z;
  logic [ADC_BITS-1:0] prev_pressure;
  logic                prev_pressure_valid;
  logic [ADC_BITS-1:0] held_x, held_y, held_pressure;
  logic                held_valid;
  logic                reported_flag;
  logic [CW-1:0]       xs, ys;
  logic                pend_release;
  logic                neg;
  logic [PW-1:0]       px, py;

  // output register
  logic          out_valid;
  logic [PW-1:0] out_x, out_y;
  logic          out_pressed, out_last;
  logic          slot_free;
  logic          out_load;

  // shared units
  rtq_pkg::mac_ctl_t     mac_ctl;
  logic signed [KW-1:0]  mac_a;
  logic [CW-1:0]         mac_b;
  logic signed [AW-1:0]  mac_add;
  logic signed [AW-1:0]  acc;
  logic                  div_start;
  logic [NW-1:0]         div_num;
  logic [DW-1:0]         div_den;
  logic                  div_done;
  logic [NW-1:0]         quo;

  rtq_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_add),
    .acc    (acc)
  );

  rtq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  function automatic logic [PW-1:0] sat16(input logic n, input logic [NW-1:0] q);
    if (n) begin
      return '0;
    end else if (|q[NW-1:PW]) begin
      return '1;
    end else begin
      return q[PW-1:0];
    end
  endfunction

  // resistance terms
  logic [EW-1:0]    x610, y1000;
  logic [CW-1:0]    q1, q2;
  logic [18:0]      term2;
  assign x610  = EW'(cur_x) * EW'(rtq_pkg::RES_X);
  assign y1000 = EW'(cur_y) * EW'(rtq_pkg::MILLI);
  assign q1    = CW'(x610 >> ADC_BITS);
  assign q2    = CW'(y1000 >> ADC_BITS);
  assign term2 = 19'(CW'(rtq_pkg::MILLI) - q2) * 19'(rtq_pkg::RES_Y);

  // scaled held point
  logic [EW-1:0]       xsc, ysc;
  logic [ADC_BITS-1:0] yinv;
  assign yinv = ADC_MASK - held_y;
  assign xsc  = {held_x, 10'b0} >> ADC_BITS;
  assign ysc  = (EW'(yinv) * EW'(rtq_pkg::SCALE_H)) >> ADC_BITS;

  // classification
  logic [ADC_BITS-1:0] jump;
  logic                stable, rel_path, rep_ok;
  assign jump     = (prev_pressure >= cur_z) ? (prev_pressure - cur_z)
                                             : (cur_z - prev_pressure);
  assign stable   = (cur_z != '0) && prev_pressure_valid &&
                    (32'(jump) <= 32'(rtq_pkg::JUMP_MAX)) &&
                    !(acc > AW'(rtq_pkg::RES_MAX));
  assign rel_path = (cur_z == '0) || (cur_z == ADC_MASK);
  assign rep_ok   = held_valid && (32'(held_pressure) > 32'(min_press));

  assign slot_free     = !out_valid || reports.ready;
  assign out_load      = ((state == ST_EMIT_P) || (state == ST_EMIT_R)) && slot_free;
  assign samples.ready = (state == ST_IDLE);

  logic [AW-1:0] acc_mag;
  logic [KW-1:0] den_mag;
  assign acc_mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign den_mag = cal[6][KW-1] ? KW'(-cal[6]) : KW'(cal[6]);

  // shared unit control
  always_comb begin
    mac_ctl   = '{en: 1'b0, accum: 1'b0};
    mac_a     = '0;
    mac_b     = '0;
    mac_add   = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      ST_IDLE: begin
        div_start = samples.valid && (samples.z1_sample != '0);
        div_num   = NW'(rtq_pkg::MILLI) << ADC_BITS;
        div_den   = DW'(samples.z1_sample);
      end
      ST_RDIV: begin
        mac_ctl = '{en: div_done, accum: 1'b0};
        mac_a   = KW'(quo - NW'(rtq_pkg::MILLI));
        mac_b   = q1;
        mac_add = -AW'(term2);
      end
      ST_MAP: begin
        mac_ctl = '{en: 1'b1, accum: 1'b0};
        mac_a   = cal[0];
        mac_b   = xs;
        mac_add = AW'(cal[2]);
      end
      ST_MAPX2, ST_MAPY2: begin
        mac_ctl = '{en: 1'b1, accum: 1'b1};
        mac_a   = (state == ST_MAPX2) ? cal[1] : cal[4];
        mac_b   = ys;
      end
      ST_XSTART, ST_YSTART: begin
        div_start = 1'b1;
        div_num   = acc_mag;
        div_den   = den_mag;
      end
      ST_XDIV: begin
        mac_ctl = '{en: div_done, accum: 1'b0};
        mac_a   = cal[3];
        mac_b   = xs;
        mac_add = AW'(cal[5]);
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) begin
        cal[i] <= '0;
      end
      min_press <= rtq_pkg::PRESS_W'(rtq_pkg::MIN_PRESS_RESET);
    end else if (cfg_we) begin
      if (cfg_index == rtq_pkg::REG_MIN_PRESS) begin
        min_press <= cfg_data[rtq_pkg::PRESS_W-1:0];
      end else begin
        cal[cfg_index] <= cfg_data;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      prev_pressure       <= '0;
      prev_pressure_valid <= 1'b0;
      held_x              <= '0;
      held_y              <= '0;
      held_pressure       <= '0;
      held_valid          <= 1'b0;
      reported_flag       <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (reports.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            cur_x <= samples.x_sample;
            cur_y <= samples.y_sample;
            cur_z <= samples.z1_sample;
            state <= (samples.z1_sample == '0) ? ST_CLASS : ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (div_done) begin
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          prev_pressure       <= cur_z;
          prev_pressure_valid <= (cur_z != '0);
          held_x              <= stable ? cur_x : '0;
          held_y              <= stable ? cur_y : '0;
          held_pressure       <= stable ? cur_z : '0;
          held_valid          <= stable;
          xs                  <= xsc[CW-1:0];
          ys                  <= ysc[CW-1:0];
          if (rel_path) begin
            reported_flag <= 1'b0;
            pend_release  <= 1'b1;
            state         <= (!reported_flag && rep_ok) ? ST_MAP : ST_EMIT_R;
          end else if (stable && rep_ok) begin
            reported_flag <= 1'b1;
            pend_release  <= 1'b0;
            state         <= ST_MAP;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MAP: begin
          // divisor zero: scaled point goes out as is
          if (cal[6] == '0) begin
            px    <= PW'(xs);
            py    <= PW'(ys);
            state <= ST_EMIT_P;
          end else begin
            state <= ST_MAPX2;
          end
        end
        ST_MAPX2: state <= ST_XSTART;
        ST_XSTART: begin
          neg   <= acc[AW-1] ^ cal[6][KW-1];
          state <= ST_XDIV;
        end
        ST_XDIV: begin
          if (div_done) begin
            px    <= sat16(neg, quo);
            state <= ST_MAPY2;
          end
        end
        ST_MAPY2: state <= ST_YSTART;
        ST_YSTART: begin
          neg   <= acc[AW-1] ^ cal[6][KW-1];
          state <= ST_YDIV;
        end
        ST_YDIV: begin
          if (div_done) begin
            py    <= sat16(neg, quo);
            state <= ST_EMIT_P;
          end
        end
        ST_EMIT_P: begin
          if (slot_free) begin
            out_x       <= px;
            out_y       <= py;
            out_pressed <= 1'b1;
            out_last    <= !pend_release;
            state       <= pend_release ? ST_EMIT_R : ST_IDLE;
          end
        end
        ST_EMIT_R: begin
          if (slot_free) begin
            out_x       <= '0;
            out_y       <= '0;
            out_pressed <= 1'b0;
            out_last    <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign reports.valid   = out_valid;
  assign reports.pos_x   = out_x;
  assign reports.pos_y   = out_y;
  assign reports.pressed = out_pressed;
  assign reports.last    = out_last;
endmodule

>>> tb/sv/tb_resistive_touch_qualifier.sv
// ----------------------------------------------------------------------------
// tb_resistive_touch_qualifier
// Self-checking bench for the touch qualifier: a directed table, then random
// touch strokes under several calibration settings, with random stalls on
// both channels. Every report is checked against an internal touch predictor.
// ----------------------------------------------------------------------------
module tb_resistive_touch_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FS        = 64'sd1 << rtq_pkg::ADC_BITS;
  localparam int     FULL      = (1 << rtq_pkg::ADC_BITS) - 1;
  localparam int     N_RANDOM  = 750;
  localparam longint MAX_CYC   = 2000000;
  localparam int     DRAIN_CYC = 400;

  typedef struct packed {
    logic [rtq_pkg::POS_W-1:0] pos_x;
    logic [rtq_pkg::POS_W-1:0] pos_y;
    logic                      pressed;
    logic                      last;
  } report_t;

  typedef struct {
    int      x;
    int      y;
    int      z;
    int      n_exp;    // -1: predictor only
    report_t r0;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rtq_pkg::IDX_W-1:0] cfg_index = '0;
  logic [rtq_pkg::COEF_W-1:0] cfg_data = '0;

  rtq_in_if  samples ();
  rtq_out_if reports ();

  resistive_touch_qualifier dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples), .reports(reports)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  longint cal_coef [7];
  int     min_press;
  int     prev_z;
  bit     prev_z_ok;
  int     hold_x, hold_y, hold_z;
  bit     hold_ok;
  bit     touch_reported;

  report_t pending_reports [$];
  int      errors = 0;
  int      n_press = 0, n_release = 0, n_inputs = 0;
  int      last_count = 0;
  longint  cycles = 0;
  bit      no_idle = 1'b0;

  function automatic longint clamp_pos(longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic report_t calibrate_point(int rx, int ry);
    report_t r;
    longint  sx, sy;
    sx = longint'(rx) * 1024 / FS;
    sy = (FS - 1 - longint'(ry)) * rtq_pkg::SCALE_H / FS;
    r.pressed = 1'b1;
    r.last = 1'b0;
    if (cal_coef[6] == 0) begin
      r.pos_x = rtq_pkg::POS_W'(clamp_pos(sx));
      r.pos_y = rtq_pkg::POS_W'(clamp_pos(sy));
    end else begin
      r.pos_x = rtq_pkg::POS_W'(clamp_pos(
                  (cal_coef[0] * sx + cal_coef[1] * sy + cal_coef[2]) / cal_coef[6]));
      r.pos_y = rtq_pkg::POS_W'(clamp_pos(
                  (cal_coef[3] * sx + cal_coef[4] * sy + cal_coef[5]) / cal_coef[6]));
    end
    return r;
  endfunction

  // classify one sample and queue the reports it should produce
  function automatic int predict_touch(int x, int y, int z);
    int      cls;  // 0 released, 1 stable, 2 unstable
    longint  res, d;
    int      sx, sy, sz;
    bit      sv;
    int      n;
    report_t r;
    n = 0;
    if (z == 0) cls = 0;
    else begin
      res = ((rtq_pkg::RES_X * longint'(x)) / FS) *
            ((FS * rtq_pkg::MILLI) / longint'(z) - rtq_pkg::MILLI)
            - (rtq_pkg::MILLI - (longint'(y) * rtq_pkg::MILLI) / FS) * rtq_pkg::RES_Y;
      d = longint'(prev_z) - longint'(z);
      if (d < 0) d = -d;
      cls = (!prev_z_ok || d > rtq_pkg::JUMP_MAX || res > rtq_pkg::RES_MAX) ? 2 : 1;
    end
    prev_z = z;
    prev_z_ok = (z != 0);
    sx = hold_x; sy = hold_y; sz = hold_z; sv = hold_ok;
    if (cls == 1) begin
      hold_x = x; hold_y = y; hold_z = z; hold_ok = 1'b1;
    end else begin
      hold_x = 0; hold_y = 0; hold_z = 0; hold_ok = 1'b0;
    end
    if (cls == 0 || z == FULL) begin
      if (!touch_reported && sv && sz > min_press) begin
        pending_reports.push_back(calibrate_point(sx, sy));
        n++;
      end
      r = '0;
      r.last = 1'b1;
      pending_reports.push_back(r);
      n++;
      touch_reported = 1'b0;
    end else if (cls == 1 && sv && sz > min_press) begin
      touch_reported = 1'b1;
      r = calibrate_point(sx, sy);
      r.last = 1'b1;
      pending_reports.push_back(r);
      n++;
    end
    return n;
  endfunction

  // report checker and receiver stalls
  always @(posedge clk) begin
    report_t got, want;
    cycles <= cycles + 1;
    if (!rst) reports.ready <= no_idle || ($urandom_range(99) >= 6);
    else reports.ready <= 1'b0;
    if (!rst && reports.valid && reports.ready) begin
      got = '{reports.pos_x, reports.pos_y, reports.pressed, reports.last};
      if (got.pressed) n_press++; else n_release++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t: report mismatch, expected x=%0d y=%0d p=%0b l=%0b, actual x=%0d y=%0d p=%0b l=%0b",
                   $time, want.pos_x, want.pos_y, want.pressed, want.last,
                   got.pos_x, got.pos_y, got.pressed, got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= MAX_CYC) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // write enable stays up across consecutive writes; caller drops it
  task automatic write_reg(logic [rtq_pkg::IDX_W-1:0] idx, logic [rtq_pkg::COEF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == rtq_pkg::REG_MIN_PRESS) min_press = int'(val[rtq_pkg::PRESS_W-1:0]);
    else cal_coef[idx] = longint'(signed'(val));
  endtask

  task automatic wait_drained();
    samples.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // valid is left high after the transfer; a drain, or an idle gap in the next call, drops it
  task automatic send_sample(int x, int y, int z);
    if (!no_idle) while ($urandom_range(99) < 6) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.x_sample <= rtq_pkg::ADC_BITS'(x);
    samples.y_sample <= rtq_pkg::ADC_BITS'(y);
    samples.z1_sample <= rtq_pkg::ADC_BITS'(z);
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    last_count = predict_touch(x, y, z);
    n_inputs++;
  endtask

  // one pen stroke: one to eight presses around a point, then a lift in most strokes
  task automatic send_stroke();
    int x, y, z, len;
    x = $urandom_range(FULL);
    y = $urandom_range(FULL);
    z = $urandom_range(1, FULL);
    len = $urandom_range(1, 8);
    repeat (len) begin
      if ($urandom_range(9) == 0) z = $urandom_range(1, FULL);
      else z = z + $urandom_range(0, 400) - 200;
      if (z < 1) z = 1;
      if (z > FULL) z = FULL;
      if ($urandom_range(19) == 0) z = FULL;
      send_sample(x ^ $urandom_range(15), y ^ $urandom_range(15), z);
    end
    if ($urandom_range(9) != 0) send_sample($urandom_range(FULL), $urandom_range(FULL), 0);
  endtask

  task automatic load_cal(int mode);
    logic [rtq_pkg::COEF_W-1:0] v [8];
    case (mode)
      0: v = '{0, 0, 0, 0, 0, 0, 0, 100};
      1: v = '{1, 0, 0, 0, 1, 0, 1, 0};
      2: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000, FULL};
      3: v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff, 32'hffffffff, 0};
      default: for (int i = 0; i < 8; i++) v[i] = $urandom_range(1) ?
                 $urandom : ($urandom_range(4000) - 2000);
    endcase
    if (mode > 3) v[7] = $urandom_range(3) == 0 ? $urandom_range(FULL) : $urandom_range(300);
    for (int i = 0; i < 8; i++) write_reg(rtq_pkg::IDX_W'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  vec_t dir_tab [$];

  initial begin
    report_t rel;
    int nq;
    rel = '0;
    rel.last = 1'b1;
    for (int i = 0; i < 7; i++) cal_coef[i] = 0;
    min_press = rtq_pkg::MIN_PRESS_RESET;
    prev_z = 0; prev_z_ok = 0; hold_x = 0; hold_y = 0; hold_z = 0; hold_ok = 0;
    touch_reported = 0;
    samples.valid = 1'b0;
    samples.x_sample = '0;
    samples.y_sample = '0;
    samples.z1_sample = '0;
    reports.ready = 1'b0;

    dir_tab = '{
      '{0, 0, 0, 1, rel},                 // release after reset
      '{2048, 2048, 1000, 0, rel},        // first press unstable
      '{2048, 2048, 1100, -1, rel},       // stable, held
      '{2000, 2000, 1200, -1, rel},       // report of held point
      '{0, 0, 0, 1, rel},                 // already reported: release only
      '{0, FULL, 2000, -1, rel},
      '{0, FULL, 2000, -1, rel},
      '{0, 0, 0, -1, rel},                // last press then release
      '{FULL, 0, 3000, -1, rel},
      '{FULL, 0, 3250, -1, rel},          // jump of exactly 250
      '{FULL, 0, 3501, -1, rel},          // jump of 251
      '{FULL, FULL, 3600, -1, rel},
      '{FULL, FULL, FULL, -1, rel},       // full scale takes release path
      '{FULL, FULL, FULL, -1, rel},
      '{4000, 100, 1, -1, rel},           // jump, then high resistance
      '{4000, 100, 1, -1, rel},
      '{100, 100, 50, -1, rel},
      '{100, 100, 60, -1, rel},           // held below min pressure
      '{100, 100, 60, -1, rel},
      '{0, 0, 0, -1, rel}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_sample(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z);
      if (dir_tab[i].n_exp >= 0 && last_count != dir_tab[i].n_exp) begin
        $display("%0t: directed row %0d, expected %0d reports, actual %0d", $time, i,
                 dir_tab[i].n_exp, last_count);
        errors++;
      end else if (dir_tab[i].n_exp == 1 && pending_reports[$] !== dir_tab[i].r0) begin
        $display("%0t: directed row %0d, expected %h, actual %h", $time, i,
                 dir_tab[i].r0, pending_reports[$]);
        errors++;
      end
    end
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      load_cal(ph);
      no_idle = (ph == 2);
      for (int k = 0; k < N_RANDOM / 8;) begin
        if ($urandom_range(9) == 0) begin
          send_sample($urandom_range(FULL), $urandom_range(FULL),
                      $urandom_range(1) ? 0 : $urandom_range(FULL));
          k++;
        end else begin
          nq = n_inputs;
          send_stroke();
          k += n_inputs - nq;
        end
        if (k % 40 == 0) wait_drained();  // sender holds off until drained
      end
      wait_drained();
    end
    no_idle = 1'b0;

    $display("Sent %0d samples over 8 calibration settings; checked %0d press and %0d release reports.",
             n_inputs, n_press, n_release);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
